[src/kse_pkg.sv]
// kse_pkg: types, constants and helpers for the keypad set-point entry block
package kse_pkg;

    // digit place codes
    localparam logic [1:0] PLACE_HUNDREDS = 2'd0;
    localparam logic [1:0] PLACE_TENS     = 2'd1;
    localparam logic [1:0] PLACE_UNITS    = 2'd2;
    localparam logic [1:0] PLACE_DONE     = 2'd3;

    // command codes
    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_KEY  = 1'b1;

    // key codes
    localparam logic [3:0] KEY_NINE = 4'd9;
    localparam logic [3:0] KEY_A    = 4'd10;
    localparam logic [3:0] KEY_D    = 4'd13;
    localparam logic [3:0] KEY_STAR = 4'd14;
    localparam logic [3:0] KEY_HASH = 4'd15;

    // edit target codes
    localparam logic [2:0] TGT_NONE     = 3'd0;
    localparam logic [2:0] TGT_OXYGEN   = 3'd1;
    localparam logic [2:0] TGT_PRESSURE = 3'd2;
    localparam logic [2:0] TGT_RATE     = 3'd3;
    localparam logic [2:0] TGT_VOLUME   = 3'd4;

    // set-point limits and reset values
    localparam logic [6:0]  OXY_MIN     = 7'd21;
    localparam logic [6:0]  OXY_MAX     = 7'd100;
    localparam logic [5:0]  PRS_MIN     = 6'd10;
    localparam logic [5:0]  PRS_MAX     = 6'd37;
    localparam logic [4:0]  RATE_MIN    = 5'd10;
    localparam logic [4:0]  RATE_MAX    = 5'd30;
    localparam logic [9:0]  VOL_MIN     = 10'd270;
    localparam logic [9:0]  VOL_MAX     = 10'd800;
    localparam logic [2:0]  MODE_MAX    = 3'd4;
    localparam logic [1:0]  RATIO_MAX   = 2'd3;
    localparam logic [6:0]  OXY_RESET   = 7'd21;
    localparam logic [5:0]  PRS_RESET   = 6'd25;
    localparam logic [4:0]  RATE_RESET  = 5'd15;
    localparam logic [9:0]  VOL_RESET   = 10'd500;
    localparam logic [15:0] TIMEOUT_RESET = 16'd1500;
    localparam logic [15:0] IDLE_MAX    = 16'hFFFF;
    localparam logic [9:0]  ACC_MAX     = 10'd1000;

    // one result transaction
    typedef struct packed {
        logic [6:0] oxygen_pct;
        logic [5:0] pressure_set;
        logic [4:0] breath_rate;
        logic [9:0] tidal_volume;
        logic [2:0] vent_mode;
        logic [1:0] ie_ratio;
        logic [2:0] editing;
    } result_t;

    // floor(v/10) by reciprocal multiply, exact for v below 1029
    function automatic logic [6:0] div10(input logic [9:0] v);
        logic [20:0] prod;
        prod = 21'(v) * 21'd205;
        return prod[17:11];
    endfunction

    // clamp a 10-bit value into [lo, hi]
    function automatic logic [9:0] clamp10(input logic [9:0] v, input logic [9:0] lo,
                                           input logic [9:0] hi);
        priority if (v < lo) return lo;
        else if (v > hi)     return hi;
        else                 return v;
    endfunction

endpackage

[src/keypad_setpoint_entry.sv]
// keypad_setpoint_entry: keypad driven set-point editor with tick based entry timeout
// each result is registered in the output register, or in the skid register behind it
// throughput: one transaction per cycle while the skid register is empty
// all state is updated in one pass at acceptance; a two-entry output buffer (output
// register plus skid register) keeps input open while one result waits to be taken
// reset: asynchronous active-low; set-points go to their defaults, timeout to 1500
module keypad_setpoint_entry (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wen,
    input  logic [15:0]                   cfg_wdata,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          cmd,
    input  logic [3:0]                    key_code,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [6:0]                    oxygen_pct,
    output logic [5:0]                    pressure_set,
    output logic [4:0]                    breath_rate,
    output logic [9:0]                    tidal_volume,
    output logic [2:0]                    vent_mode,
    output logic [1:0]                    ie_ratio,
    output logic [2:0]                    editing
);
    import kse_pkg::*;

    logic [15:0] timeout_reg;
    logic [2:0]  target_reg,   target_next;
    logic [1:0]  place_reg,    place_next;
    logic [9:0]  acc_reg,      acc_next;
    logic [15:0] idle_reg,     idle_next;
    logic [6:0]  oxygen_reg,   oxygen_next;
    logic [5:0]  pressure_reg, pressure_next;
    logic [4:0]  rate_reg,     rate_next;
    logic [9:0]  volume_reg,   volume_next;
    logic [2:0]  mode_reg,     mode_next;
    logic [1:0]  ratio_reg,    ratio_next;

    logic        out_valid_reg, out_valid_next;
    logic        skid_valid_reg, skid_valid_next;
    result_t     out_data_reg;
    result_t     skid_data_reg;
    result_t     res;

    logic        in_fire;
    logic        out_fire;
    logic [9:0]  digit_val;
    logic [9:0]  acc_div;

    assign in_ready  = !skid_valid_reg;
    assign in_fire   = in_valid && in_ready;
    assign out_fire  = out_valid_reg && out_ready;
    assign digit_val = {6'd0, key_code};

    // set-point state update for one transaction
    always_comb
    begin
        target_next   = target_reg;
        place_next    = place_reg;
        acc_next      = acc_reg;
        idle_next     = idle_reg;
        oxygen_next   = oxygen_reg;
        pressure_next = pressure_reg;
        rate_next     = rate_reg;
        volume_next   = volume_reg;
        mode_next     = mode_reg;
        ratio_next    = ratio_reg;
        acc_div       = 10'd0;

        if (cmd == CMD_TICK)
        begin
            if (idle_reg != IDLE_MAX)
                idle_next = idle_reg + 16'd1;
        end
        else
        begin
            priority if (key_code >= KEY_A && key_code <= KEY_D)
            begin
                target_next = 3'(key_code - KEY_NINE);
                place_next  = PLACE_HUNDREDS;
                acc_next    = 10'd0;
                idle_next   = 16'd0;
            end
            else if (key_code == KEY_STAR)
            begin
                mode_next = (mode_reg >= MODE_MAX) ? 3'd1 : mode_reg + 3'd1;
            end
            else if (key_code == KEY_HASH)
            begin
                ratio_next = (ratio_reg >= RATIO_MAX) ? 2'd1 : ratio_reg + 2'd1;
            end
            else if (target_reg != TGT_NONE)
            begin
                // accumulate the digit at hundreds or tens; at units only a nine adds ten
                unique case (place_reg)
                    PLACE_HUNDREDS:
                    begin
                        acc_next   = acc_reg + 10'(digit_val * 10'd100);
                        place_next = PLACE_TENS;
                    end
                    PLACE_TENS:
                    begin
                        acc_next   = acc_reg + 10'(digit_val * 10'd10);
                        place_next = PLACE_UNITS;
                    end
                    PLACE_UNITS:
                    begin
                        if (key_code == KEY_NINE)
                            acc_next = acc_reg + 10'd10;
                        place_next = PLACE_DONE;
                    end
                    PLACE_DONE:
                    begin
                        place_next = PLACE_DONE;
                    end
                endcase

                // reload the edited set-point, clamped
                acc_div = {3'd0, div10(acc_next)};
                unique case (target_reg)
                    TGT_OXYGEN:
                        oxygen_next = 7'(clamp10(acc_div, 10'(OXY_MIN), 10'(OXY_MAX)));
                    TGT_PRESSURE:
                        pressure_next = 6'(clamp10(acc_div, 10'(PRS_MIN), 10'(PRS_MAX)));
                    TGT_RATE:
                        rate_next = 5'(clamp10(acc_div, 10'(RATE_MIN), 10'(RATE_MAX)));
                    default:
                        volume_next = clamp10(acc_next, VOL_MIN, VOL_MAX);
                endcase
                idle_next = 16'd0;
            end
            else
            begin
                // digit with nothing selected is ignored
            end

            // entry timeout, checked on key presses only
            if (idle_next >= timeout_reg)
            begin
                target_next = TGT_NONE;
                place_next  = PLACE_HUNDREDS;
                acc_next    = 10'd0;
            end
        end
    end

    // result assembled from the updated state
    always_comb
    begin
        res.oxygen_pct   = oxygen_next;
        res.pressure_set = pressure_next;
        res.breath_rate  = rate_next;
        res.tidal_volume = volume_next;
        res.vent_mode    = mode_next;
        res.ie_ratio     = ratio_next;
        res.editing      = target_next;
    end

    // output register and skid register valid flags
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (out_fire)
        begin
            if (skid_valid_reg)
                skid_valid_next = 1'b0;
            else
                out_valid_next = in_fire;
        end
        else if (!out_valid_reg)
            out_valid_next = in_fire;
        else if (in_fire)
            skid_valid_next = 1'b1;
    end

    // control and set-point registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg    <= TIMEOUT_RESET;
            target_reg     <= TGT_NONE;
            place_reg      <= PLACE_HUNDREDS;
            acc_reg        <= 10'd0;
            idle_reg       <= 16'd0;
            oxygen_reg     <= OXY_RESET;
            pressure_reg   <= PRS_RESET;
            rate_reg       <= RATE_RESET;
            volume_reg     <= VOL_RESET;
            mode_reg       <= 3'd1;
            ratio_reg      <= 2'd1;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wen)
                timeout_reg <= cfg_wdata;
            if (in_fire)
            begin
                target_reg   <= target_next;
                place_reg    <= place_next;
                acc_reg      <= acc_next;
                idle_reg     <= idle_next;
                oxygen_reg   <= oxygen_next;
                pressure_reg <= pressure_next;
                rate_reg     <= rate_next;
                volume_reg   <= volume_next;
                mode_reg     <= mode_next;
                ratio_reg    <= ratio_next;
            end
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // result payload registers
    always_ff @(posedge clk)
    begin
        if (out_fire && skid_valid_reg)
            out_data_reg <= skid_data_reg;
        else if (in_fire && (out_fire || !out_valid_reg))
            out_data_reg <= res;
        if (in_fire && out_valid_reg && !out_fire)
            skid_data_reg <= res;
    end

    assign out_valid    = out_valid_reg;
    assign oxygen_pct   = out_data_reg.oxygen_pct;
    assign pressure_set = out_data_reg.pressure_set;
    assign breath_rate  = out_data_reg.breath_rate;
    assign tidal_volume = out_data_reg.tidal_volume;
    assign vent_mode    = out_data_reg.vent_mode;
    assign ie_ratio     = out_data_reg.ie_ratio;
    assign editing      = out_data_reg.editing;

    // skid register only fills behind a waiting output
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register valid without output register valid");

    // a tick never changes the entry target
    a_tick_keeps_target: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && cmd == CMD_TICK) |=> $stable(target_reg))
        else $error("tick altered the edit target");

    // accumulator stays within the reachable range
    a_acc_range: assert property (@(posedge clk) disable iff (!rst_n)
        acc_reg <= ACC_MAX)
        else $error("accumulator out of range");

    // a shown result stays in place while stalled
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> (out_valid_reg && $stable(out_data_reg)))
        else $error("stalled result changed");

    // entry at the hundreds place has an empty accumulator
    a_place_acc: assert property (@(posedge clk) disable iff (!rst_n)
        (place_reg == PLACE_HUNDREDS) |-> (acc_reg == 10'd0))
        else $error("accumulator non-zero at hundreds place");

endmodule
